>>> hw/rtl/rlps_pkg.sv
// Shared types and constants for the RGBW LED strip pulse serializer.
// Holds transaction structs, operation codes, register indexes and reset values.
// No dependencies.
package rlps_pkg;

    // Operation codes of an input transaction
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd4;

    localparam int PULSE_W = 10;
    localparam int GAP_W   = 16;
    localparam int CFG_DATA_W = 16;

    // Reset values of the timing registers (nanoseconds over a 5 ns tick)
    localparam logic [PULSE_W-1:0] RST_ONE_HIGH  = PULSE_W'(700 / 5);
    localparam logic [PULSE_W-1:0] RST_ONE_LOW   = PULSE_W'(800 / 5);
    localparam logic [PULSE_W-1:0] RST_ZERO_HIGH = PULSE_W'(350 / 5);
    localparam logic [PULSE_W-1:0] RST_ZERO_LOW  = PULSE_W'(600 / 5);
    localparam logic [GAP_W-1:0]   RST_GAP       = GAP_W'(60000 / 5);

    // Queue between front and back; depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic        opcode;
        logic [2:0]  led_index;
        logic [31:0] color_word;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic frame_done;
    } t_out_item;

    typedef struct packed {
        logic [PULSE_W-1:0] one_high;
        logic [PULSE_W-1:0] one_low;
        logic [PULSE_W-1:0] zero_high;
        logic [PULSE_W-1:0] zero_low;
        logic [GAP_W-1:0]   gap;
    } t_timing;

    // Classified command passed from front to back
    typedef struct packed {
        logic        is_write;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_cmd;

endpackage

>>> hw/rtl/rgbw_led_strip_pulse_serializer_top.sv
// Top level of the RGBW LED strip pulse serializer: timing registers and wiring
// of front stage, command queue and back stage. Depends on rlps_pkg and all rlps_* modules.
//
// Drives a one-wire RGBW strip from a table of color words. Each input
// transaction is either a tick (one timebase clock, answered by one output
// transaction with the line level and a frame-done flag) or a color write
// (no output). The block sustains one transaction per clock cycle while
// o_in_stall stays low. An accepted tick passes through the input register,
// the queue and the output register before its output is valid. The
// two-entry queue lets the input and output sides stall independently.
// The user must write timing registers through the plain configuration port
// only while the block is idle; the block itself does not enforce it. Only
// LEDs 0..7 are addressable; further LEDs of a longer strip are sent as zero.
module rgbw_led_strip_pulse_serializer_top
    import rlps_pkg::*;
#(
    parameter int NUM_LEDS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_timing r_timing;
    logic    push;
    logic    full;
    logic    pop;
    logic    q_valid;
    t_cmd    front_cmd;
    t_cmd    back_cmd;

    // Write timing registers; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.one_high  <= RST_ONE_HIGH;
            r_timing.one_low   <= RST_ONE_LOW;
            r_timing.zero_high <= RST_ZERO_HIGH;
            r_timing.zero_low  <= RST_ZERO_LOW;
            r_timing.gap       <= RST_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ONE_HIGH:  r_timing.one_high  <= i_cfg_wdata[PULSE_W-1:0];
                CFG_ONE_LOW:   r_timing.one_low   <= i_cfg_wdata[PULSE_W-1:0];
                CFG_ZERO_HIGH: r_timing.zero_high <= i_cfg_wdata[PULSE_W-1:0];
                CFG_ZERO_LOW:  r_timing.zero_low  <= i_cfg_wdata[PULSE_W-1:0];
                CFG_GAP:       r_timing.gap       <= i_cfg_wdata[GAP_W-1:0];
                default:       r_timing <= r_timing;
            endcase
        end
    end

    rlps_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (full)
    );

    rlps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (back_cmd)
    );

    rlps_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timing    (r_timing),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hw/rtl/rlps_front.sv
// Front stage: registers input transactions and classifies them into commands.
// Drops writes to LEDs beyond the strip. Depends on rlps_pkg.
module rlps_front
    import rlps_pkg::*;
#(
    parameter int NUM_LEDS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_push,
    output t_cmd     o_cmd,
    input  logic     i_full
);

    logic     r_valid;
    t_in_item r_item;
    logic     keep;
    logic     done;

    // Classify: a write beyond the strip is consumed without a queue slot
    assign keep = !((r_item.opcode == OP_WRITE) && !(32'(r_item.led_index) < NUM_LEDS));
    assign done = r_valid && (!keep || !i_full);

    assign o_in_stall = r_valid && !done;
    assign o_push     = r_valid && keep && !i_full;

    assign o_cmd.is_write = (r_item.opcode == OP_WRITE);
    assign o_cmd.idx      = r_item.led_index;
    assign o_cmd.data     = r_item.color_word;

    // Hold or advance the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || done) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
    end

endmodule

>>> hw/rtl/rlps_fifo.sv
// Short command queue between front and back stages.
// Register-based, depth from rlps_pkg. Depends on rlps_pkg.
module rlps_fifo
    import rlps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");

endmodule

>>> hw/rtl/rlps_back.sv
// Back stage: applies color writes and runs the bit pulse sequencer per tick.
// Owns the color table and the output register. Depends on rlps_pkg.
module rlps_back
    import rlps_pkg::*;
#(
    parameter int NUM_LEDS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_timing   i_timing,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Only the first eight LEDs are writable; the rest always read as zero
    localparam int TD  = (NUM_LEDS < 8) ? NUM_LEDS : 8;
    localparam int TIW = (TD > 1) ? $clog2(TD) : 1;
    localparam int LW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LW-1:0] LED_LAST = LW'(NUM_LEDS - 1);

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } t_phase;

    logic [31:0] r_table [TD];
    t_phase      r_phase,     n_phase;
    logic [LW-1:0] r_led_pos, n_led_pos;
    logic [4:0]  r_bit_pos,   n_bit_pos;
    logic [15:0] r_tick,      n_tick;
    logic        r_bit_value, n_bit_value;
    logic        r_out_valid;
    t_out_item   r_out,       n_out;

    logic        out_free;
    logic        do_write;
    logic        do_tick;
    logic [31:0] tbl_word;
    logic        bv;
    logic [16:0] cnt_inc;
    logic [16:0] len;

    assign out_free = !r_out_valid || !i_out_stall;
    assign do_write = i_q_valid && i_cmd.is_write;
    assign do_tick  = i_q_valid && !i_cmd.is_write && out_free;
    assign o_pop    = do_write || do_tick;

    assign tbl_word = (32'(r_led_pos) < TD) ? r_table[r_led_pos[TIW-1:0]] : '0;
    // Sample the bit on the first tick of its high pulse
    assign bv       = (r_tick == '0) ? tbl_word[r_bit_pos] : r_bit_value;
    assign cnt_inc  = {1'b0, r_tick} + 17'd1;

    // Next state of the pulse sequencer for one tick
    always_comb begin
        n_phase     = r_phase;
        n_led_pos   = r_led_pos;
        n_bit_pos   = r_bit_pos;
        n_tick      = cnt_inc[15:0];
        n_bit_value = r_bit_value;
        n_out       = '0;
        len         = '0;
        unique case (r_phase)
            PH_HIGH: begin
                n_out.line_level = 1'b1;
                n_bit_value      = bv;
                len = 17'(bv ? i_timing.one_high : i_timing.zero_high);
                if (cnt_inc >= len) begin
                    n_tick  = '0;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                len = 17'(r_bit_value ? i_timing.one_low : i_timing.zero_low);
                if (cnt_inc >= len) begin
                    n_tick  = '0;
                    n_phase = PH_HIGH;
                    if (r_bit_pos == '0) begin
                        n_bit_pos = 5'd31;
                        if (r_led_pos == LED_LAST) begin
                            n_led_pos = '0;
                            n_phase   = PH_GAP;
                        end else begin
                            n_led_pos = r_led_pos + 1'b1;
                        end
                    end else begin
                        n_bit_pos = r_bit_pos - 5'd1;
                    end
                end
            end
            PH_GAP: begin
                len = 17'(i_timing.gap);
                if (cnt_inc >= len) begin
                    n_tick           = '0;
                    n_out.frame_done = 1'b1;
                    n_phase          = PH_HIGH;
                end
            end
            default: begin
                n_phase = PH_HIGH;
                n_tick  = '0;
            end
        endcase
    end

    // Hold sequencer state, color table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HIGH;
            r_led_pos   <= '0;
            r_bit_pos   <= 5'd31;
            r_tick      <= '0;
            r_bit_value <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TD; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            if (do_write) begin
                r_table[i_cmd.idx[TIW-1:0]] <= i_cmd.data;
            end
            if (do_tick) begin
                r_phase     <= n_phase;
                r_led_pos   <= n_led_pos;
                r_bit_pos   <= n_bit_pos;
                r_tick      <= n_tick;
                r_bit_value <= n_bit_value;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_gap_at_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GAP) |-> (r_led_pos == '0 && r_bit_pos == 5'd31))
        else $error("latch gap entered with sequencer mid-frame");

    a_done_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> !r_out.line_level)
        else $error("frame done flagged while line high");

    a_no_tick_into_held_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !do_tick)
        else $error("tick executed while output slot held");

endmodule

>>> dv/tb_rgbw_led_strip_pulse_serializer_top.sv
// Self-checking testbench for the RGBW LED strip pulse serializer.
// Predicts line level and frame-done per tick, runs several timing settings.
// Depends on rlps_pkg and rgbw_led_strip_pulse_serializer_top.
`timescale 1ns / 1ps

module tb_rgbw_led_strip_pulse_serializer_top;
    import rlps_pkg::*;

    localparam int LED_COUNT     = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {
        SEND_HIGH,
        SEND_LOW,
        SEND_GAP
    } t_strip_phase;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    rgbw_led_strip_pulse_serializer_top #(
        .NUM_LEDS(LED_COUNT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Strip state as the block should hold it
    logic [31:0]  color_words [LED_COUNT];
    int           one_high_len  = int'(RST_ONE_HIGH);
    int           one_low_len   = int'(RST_ONE_LOW);
    int           zero_high_len = int'(RST_ZERO_HIGH);
    int           zero_low_len  = int'(RST_ZERO_LOW);
    int           gap_len       = int'(RST_GAP);
    t_strip_phase strip_phase   = SEND_HIGH;
    int           strip_led     = 0;
    int           strip_bit     = 31;
    int           phase_ticks   = 0;
    logic         cur_bit_val   = 1'b0;

    t_in_item  items_to_send [$];
    t_out_item expected_line [$];
    int        mismatch_count = 0;

    // Idle pacing per side: 0 = sender, 1 = receiver
    int run_left [2] = '{0, 0};
    bit no_idle  [2] = '{1'b0, 1'b0};
    int send_wait  = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Draw the wait before the next transaction; switch between calm and busy runs
    function automatic int draw_wait(int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(10, 60);
            no_idle[side]  = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return no_idle[side] ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_in_item make_item(logic op, logic [2:0] idx, logic [31:0] word);
        t_in_item item;
        item.opcode     = op;
        item.led_index  = idx;
        item.color_word = word;
        return item;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endtask

    // Apply one accepted transaction to the strip state; queue the tick's line output
    task automatic advance_strip(input t_in_item item);
        t_out_item res;
        int        len;
        res = '0;
        if (item.opcode == OP_WRITE) begin
            color_words[item.led_index] = item.color_word;
        end else begin
            case (strip_phase)
                SEND_HIGH: begin
                    // sample the bit on the first tick of its high pulse
                    if (phase_ticks == 0) cur_bit_val = color_words[strip_led][strip_bit];
                    res.line_level = 1'b1;
                    len = cur_bit_val ? one_high_len : zero_high_len;
                    phase_ticks++;
                    if (phase_ticks >= len) begin
                        phase_ticks = 0;
                        strip_phase = SEND_LOW;
                    end
                end
                SEND_LOW: begin
                    len = cur_bit_val ? one_low_len : zero_low_len;
                    phase_ticks++;
                    if (phase_ticks >= len) begin
                        phase_ticks = 0;
                        strip_phase = SEND_HIGH;
                        if (strip_bit != 0) begin
                            strip_bit--;
                        end else begin
                            strip_bit = 31;
                            if (strip_led == LED_COUNT - 1) begin
                                strip_led   = 0;
                                strip_phase = SEND_GAP;
                            end else begin
                                strip_led++;
                            end
                        end
                    end
                end
                default: begin
                    phase_ticks++;
                    if (phase_ticks >= gap_len) begin
                        phase_ticks    = 0;
                        res.frame_done = 1'b1;
                        strip_phase    = SEND_HIGH;
                    end
                end
            endcase
            expected_line.push_back(res);
        end
    endtask

    // Write one timing register and mirror it in the predicted settings
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_ONE_HIGH:  one_high_len  = int'(data[PULSE_W-1:0]);
            CFG_ONE_LOW:   one_low_len   = int'(data[PULSE_W-1:0]);
            CFG_ZERO_HIGH: zero_high_len = int'(data[PULSE_W-1:0]);
            CFG_ZERO_LOW:  zero_low_len  = int'(data[PULSE_W-1:0]);
            CFG_GAP:       gap_len       = int'(data[GAP_W-1:0]);
            default: ;
        endcase
    endtask

    // Load all timing registers, poke one unused index, then release the port
    task automatic apply_timing(input logic [CFG_DATA_W-1:0] one_high,
                                input logic [CFG_DATA_W-1:0] one_low,
                                input logic [CFG_DATA_W-1:0] zero_high,
                                input logic [CFG_DATA_W-1:0] zero_low,
                                input logic [CFG_DATA_W-1:0] gap);
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ONE_LOW, one_low);
        write_reg(CFG_ZERO_HIGH, zero_high);
        write_reg(CFG_ZERO_LOW, zero_low);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_IDX_W'($urandom_range(CFG_GAP + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom()));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Fill the send queue with mostly ticks and some color writes
    task automatic queue_random(input int count);
        t_in_item item;
        for (int n = 0; n < count; n++) begin
            item.opcode    = ($urandom_range(0, 99) < 85) ? OP_TICK : OP_WRITE;
            item.led_index = 3'($urandom_range(0, LED_COUNT - 1));
            case ($urandom_range(0, 3))
                0: item.color_word = '1;
                1: item.color_word = '0;
                default: item.color_word = $urandom();
            endcase
            items_to_send.push_back(item);
        end
    endtask

    // Wait until every transaction is sent and every tick output has come back
    task automatic drain();
        while (items_to_send.size() != 0 || i_in_valid || expected_line.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Send pending transactions; predict each one as it is accepted
    always @(posedge i_clk) begin : send_proc
        bit taken;
        int wait_now;
        taken    = i_in_valid && !o_in_stall;
        wait_now = send_wait;
        if (taken) begin
            advance_strip(i_in_data);
            void'(items_to_send.pop_front());
            wait_now = draw_wait(0);
        end
        if (i_in_valid && !taken) begin
            // hold the stalled transaction
        end else if (wait_now == 0 && items_to_send.size() != 0) begin
            i_in_valid <= 1'b1;
            i_in_data  <= items_to_send[0];
        end else begin
            i_in_valid <= 1'b0;
            if (wait_now > 0) wait_now--;
        end
        send_wait = wait_now;
    end

    // Accept tick outputs, compare with the oldest prediction, stall at random
    always @(posedge i_clk) begin : check_proc
        int        hold_now;
        t_out_item want;
        hold_now = (stall_left > 0) ? stall_left - 1 : 0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_line.size() == 0) begin
                note_mismatch($sformatf("unexpected output line=%0b done=%0b",
                                        o_out_data.line_level, o_out_data.frame_done));
            end else begin
                want = expected_line.pop_front();
                if (o_out_data.line_level !== want.line_level ||
                    o_out_data.frame_done !== want.frame_done)
                    note_mismatch($sformatf("expected line=%0b done=%0b, got line=%0b done=%0b",
                                            want.line_level, want.frame_done,
                                            o_out_data.line_level, o_out_data.frame_done));
            end
            hold_now = draw_wait(1);
        end
        stall_left = hold_now;
        i_out_stall <= (hold_now != 0);
    end

    initial begin : stimulus
        for (int k = 0; k < LED_COUNT; k++) color_words[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: first bit sampled from the cleared table, then a write to
        // the LED being sent must not change the bit already started
        items_to_send.push_back(make_item(OP_TICK, 3'd0, '0));
        items_to_send.push_back(make_item(OP_WRITE, 3'd0, 32'hFFFF_FFFF));
        for (int k = 0; k < 3; k++) items_to_send.push_back(make_item(OP_TICK, 3'd7, '1));
        items_to_send.push_back(make_item(OP_WRITE, 3'd7, 32'hFFFF_FFFF));
        items_to_send.push_back(make_item(OP_WRITE, 3'd1, 32'h8000_0001));
        items_to_send.push_back(make_item(OP_WRITE, 3'd2, 32'hAAAA_AAAA));
        items_to_send.push_back(make_item(OP_WRITE, 3'd3, 32'h5555_5555));
        items_to_send.push_back(make_item(OP_WRITE, 3'd4, 32'h0000_0000));
        items_to_send.push_back(make_item(OP_WRITE, 3'd5, 32'h0000_FFFF));
        items_to_send.push_back(make_item(OP_WRITE, 3'd6, $urandom()));
        for (int k = 0; k < 6; k++) items_to_send.push_back(make_item(OP_TICK, 3'd0, '0));
        drain();

        // Zero lengths, which must act as one tick, with the upper data bits set
        apply_timing(16'hFC00, 16'hFC00, 16'hFC00, 16'hFC00, 16'h0000);
        queue_random(250);
        drain();

        // Shortest legal timing
        apply_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        queue_random(300);
        drain();

        // Longest timing
        apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(60);
        drain();

        // Random short timing
        apply_timing(CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(1, 4)),
                     CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(1, 4)),
                     CFG_DATA_W'($urandom_range(1, 8)));
        queue_random(200);
        drain();

        // Uneven timing with stray upper bits
        apply_timing(16'h0401, 16'h8003, 16'h0002, 16'h0001, 16'h0003);
        queue_random(200);
        drain();

        // Back to the power-up timing
        apply_timing(CFG_DATA_W'(RST_ONE_HIGH), CFG_DATA_W'(RST_ONE_LOW),
                     CFG_DATA_W'(RST_ZERO_HIGH), CFG_DATA_W'(RST_ZERO_LOW),
                     CFG_DATA_W'(RST_GAP));
        queue_random(60);
        drain();

        // Short timing again to finish more frames
        apply_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
        queue_random(200);
        drain();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> rgbw_led_strip_pulse_serializer_top.f
hw/rtl/rlps_pkg.sv
hw/rtl/rlps_front.sv
hw/rtl/rlps_fifo.sv
hw/rtl/rlps_back.sv
hw/rtl/rgbw_led_strip_pulse_serializer_top.sv
dv/tb_rgbw_led_strip_pulse_serializer_top.sv
